>>> src/ednp_pkg.sv
// ============================================================================
// ednp_pkg
// Shared types, codes and helper functions for the exponential delta
// nibble packer.
// ============================================================================
package ednp_pkg;

    typedef logic [3:0] code_t;
    typedef logic [7:0] byte_t;

    localparam code_t CODE_LARGE     = 4'd0;
    localparam code_t CODE_ZERO_STEP = 4'd8;
    localparam code_t CODE_POS_BASE  = 4'd9;
    localparam code_t CODE_NEG_BASE  = 4'd7;

    localparam byte_t STEP_TABLE [16] = '{
        8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF,
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    // Largest power-of-two step not exceeding |d|, signed by d.
    function automatic code_t encode_delta(input logic signed [8:0] d);
        logic [8:0] neg_d;
        logic [6:0] mag;
        logic [2:0] msb;
        code_t      code;
        neg_d = 9'(-d);
        mag   = d[8] ? neg_d[6:0] : d[6:0];
        msb   = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (mag[i]) begin
                msb = 3'(i);
            end
        end
        if (d >= 9'sd128 || d <= -9'sd128) begin
            code = CODE_LARGE;
        end else if (d == 9'sd0) begin
            code = CODE_ZERO_STEP;
        end else if (d[8]) begin
            code = CODE_NEG_BASE - code_t'(msb);
        end else begin
            code = CODE_POS_BASE + code_t'(msb);
        end
        return code;
    endfunction

endpackage

>>> src/ednp_if.sv
// ============================================================================
// ednp_sample_if / ednp_byte_if
// Valid/ready channels for the input samples and the packed output bytes.
// ============================================================================
interface ednp_sample_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample_value;
    logic              end_of_block;

    modport source (output valid, output sample_value, output end_of_block, input ready);
    modport sink   (input valid, input sample_value, input end_of_block, output ready);
endinterface

interface ednp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;

    modport source (output valid, output packed_byte, output final_byte, input ready);
    modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

>>> src/exp_delta_nibble_packer.sv
// ============================================================================
// exp_delta_nibble_packer
// Codes signed 8-bit samples as 4-bit exponential delta steps against a
// running prediction and packs two codes per byte, first code high.
// ============================================================================
//  channel     role   payload
//  sample_ch   sink   sample_value[7:0] signed, end_of_block
//  packed_ch   source packed_byte[7:0], final_byte
//
//  One sample per cycle sustained while the output register is not stalled:
//  input register, then subtract / encode / predictor add into the output
//  register.
//  A stalled output register holds the input stage only when that sample
//  completes a byte. rst_n clears prediction, held code and valids.
// ============================================================================
module exp_delta_nibble_packer (
    input  logic                clk,
    input  logic                rst_n,
    ednp_sample_if.sink         sample_ch,
    ednp_byte_if.source         packed_ch
);

    logic                stg_valid_reg;
    logic signed [7:0]   stg_sample_reg;
    logic                stg_eob_reg;

    logic [7:0]          pred_reg;
    logic [7:0]          pred_next;
    ednp_pkg::code_t     held_reg;
    ednp_pkg::code_t     held_next;
    logic                waiting_reg;
    logic                waiting_next;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                out_final_reg;

    logic signed [8:0]   delta;
    ednp_pkg::code_t     code;
    logic                produce;
    logic                stg_advance;
    logic                sample_take;

    assign delta   = 9'(stg_sample_reg) - 9'($signed(pred_reg));
    assign code    = ednp_pkg::encode_delta(delta);
    assign produce = waiting_reg || stg_eob_reg;

    assign stg_advance = stg_valid_reg && (!produce || !out_valid_reg || packed_ch.ready);
    assign sample_ch.ready = !stg_valid_reg || stg_advance;
    assign sample_take = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        pred_next     = pred_reg + ednp_pkg::STEP_TABLE[code];
        held_next     = held_reg;
        waiting_next  = waiting_reg;
        out_byte_next = {held_reg, code};
        if (waiting_reg) begin
            held_next    = '0;
            waiting_next = 1'b0;
        end else if (stg_eob_reg) begin
            out_byte_next = {code, ednp_pkg::CODE_ZERO_STEP};
        end else begin
            held_next    = code;
            waiting_next = 1'b1;
        end
        if (stg_eob_reg) begin
            pred_next    = '0;
            held_next    = '0;
            waiting_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
            pred_reg      <= '0;
            held_reg      <= '0;
            waiting_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sample_take) begin
                stg_valid_reg <= 1'b1;
            end else if (stg_advance) begin
                stg_valid_reg <= 1'b0;
            end
            if (stg_advance) begin
                pred_reg    <= pred_next;
                held_reg    <= held_next;
                waiting_reg <= waiting_next;
            end
            if (stg_advance && produce) begin
                out_valid_reg <= 1'b1;
            end else if (packed_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take) begin
            stg_sample_reg <= sample_ch.sample_value;
            stg_eob_reg    <= sample_ch.end_of_block;
        end
        if (stg_advance && produce) begin
            out_byte_reg  <= out_byte_next;
            out_final_reg <= stg_eob_reg;
        end
    end

    assign packed_ch.valid       = out_valid_reg;
    assign packed_ch.packed_byte = out_byte_reg;
    assign packed_ch.final_byte  = out_final_reg;

endmodule
